[design/rds_pkg.sv]
// Shared types and constants for the reliable datagram sequencer.
package rds_pkg;

    localparam int unsigned SEQ_W  = 31;
    localparam int unsigned CNT_W  = 32;
    localparam int unsigned LEN_W  = 14;
    localparam int unsigned DATA_W = 32;
    localparam int unsigned ADDR_W = 3;

    localparam logic [LEN_W-1:0] HDR_BYTES       = 14'd8;
    localparam logic [LEN_W-1:0] MAX_MESSAGE     = 14'd8192;
    localparam logic [LEN_W-1:0] MAX_PKT_RESET   = 14'd8200;
    localparam logic [ADDR_W-1:0] ADDR_MAX_PACKET = 3'd0;

    localparam logic ACT_TX = 1'b0;
    localparam logic ACT_RX = 1'b1;

    typedef enum logic [2:0] {
        ST_SENT       = 3'd0,
        ST_FATAL      = 3'd1,
        ST_ACCEPTED   = 3'd2,
        ST_WRONG_ADDR = 3'd3,
        ST_STALE      = 3'd4
    } t_status;

    typedef struct packed {
        logic             action;
        logic [LEN_W-1:0] pending_bytes;
        logic             pending_overflowed;
        logic [LEN_W-1:0] unreliable_bytes;
        logic             from_remote;
        logic [31:0]      rx_seq_word;
        logic [31:0]      rx_ack_word;
    } t_item;

    typedef struct packed {
        t_status          status;
        logic [31:0]      hdr_seq_word;
        logic [31:0]      hdr_ack_word;
        logic [LEN_W-1:0] reliable_sent_bytes;
        logic             unreliable_included;
        logic [LEN_W-1:0] packet_bytes;
        logic             took_pending;
        logic [SEQ_W-1:0] packets_lost;
        logic             reliable_idle;
        logic [CNT_W-1:0] drop_total;
        logic [CNT_W-1:0] good_total;
    } t_result;

    typedef struct packed {
        logic [SEQ_W-1:0] out_seq;
        logic [SEQ_W-1:0] in_seq;
        logic [SEQ_W-1:0] last_rel_seq;
        logic [SEQ_W-1:0] peer_ack_seq;
        logic             rel_bit;
        logic             in_rel_bit;
        logic             peer_ack_bit;
        logic             fatal_flag;
        logic [LEN_W-1:0] outstanding_len;
        logic [CNT_W-1:0] drop_cnt;
        logic [CNT_W-1:0] good_cnt;
    } t_state;

endpackage

[design/rds_cfg.sv]
// APB configuration register file: packet capacity.
module rds_cfg (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [rds_pkg::ADDR_W-1:0]    paddr,
    input  logic [rds_pkg::DATA_W-1:0]    pwdata,
    output logic [rds_pkg::DATA_W-1:0]    prdata,
    output logic                          pready,
    output logic [rds_pkg::LEN_W-1:0]     o_max_packet_bytes
);

    logic [rds_pkg::LEN_W-1:0] r_max_packet_bytes;
    logic [rds_pkg::LEN_W-1:0] n_max_packet_bytes;
    logic                      wr_hit;

    assign pready = 1'b1;
    assign wr_hit = psel && penable && pwrite && (paddr == rds_pkg::ADDR_MAX_PACKET);

    always_comb begin
        n_max_packet_bytes = r_max_packet_bytes;
        if (wr_hit) begin
            n_max_packet_bytes = pwdata[rds_pkg::LEN_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_packet_bytes <= rds_pkg::MAX_PKT_RESET;
        end else begin
            r_max_packet_bytes <= n_max_packet_bytes;
        end
    end

    always_comb begin
        prdata = '0;
        if (paddr == rds_pkg::ADDR_MAX_PACKET) begin
            prdata = {{(rds_pkg::DATA_W-rds_pkg::LEN_W){1'b0}}, r_max_packet_bytes};
        end
    end

    assign o_max_packet_bytes = r_max_packet_bytes;

endmodule

[design/rds_step.sv]
// Per-item step logic: builds the result and the next channel state.
module rds_step (
    input  rds_pkg::t_item              i_item,
    input  rds_pkg::t_state             i_state,
    input  logic [rds_pkg::LEN_W-1:0]   i_max_packet_bytes,
    output rds_pkg::t_result            o_result,
    output rds_pkg::t_state             o_next_state
);

    rds_pkg::t_state           n_st;
    rds_pkg::t_result          res;
    logic                      send;
    logic [rds_pkg::LEN_W-1:0] pend_sat;
    logic [rds_pkg::LEN_W-1:0] used_base;
    logic [rds_pkg::LEN_W:0]   used_total;
    logic [rds_pkg::SEQ_W-1:0] rx_seq;
    logic [rds_pkg::SEQ_W-1:0] gap;

    assign pend_sat = (i_item.pending_bytes > rds_pkg::MAX_MESSAGE) ?
                      rds_pkg::MAX_MESSAGE : i_item.pending_bytes;
    assign rx_seq   = i_item.rx_seq_word[rds_pkg::SEQ_W-1:0];
    assign gap      = rx_seq - i_state.in_seq - {{(rds_pkg::SEQ_W-1){1'b0}}, 1'b1};

    always_comb begin
        n_st       = i_state;
        res        = '0;
        res.status = rds_pkg::ST_SENT;
        send       = 1'b0;
        used_base  = rds_pkg::HDR_BYTES;
        used_total = '0;
        case (i_item.action)
            rds_pkg::ACT_TX: begin
                if (i_item.pending_overflowed) begin
                    n_st.fatal_flag = 1'b1;
                    res.status      = rds_pkg::ST_FATAL;
                end else begin
                    // resend when the peer acked past our last reliable packet with the other ack bit
                    send = (i_state.peer_ack_seq > i_state.last_rel_seq) &&
                           (i_state.peer_ack_bit != i_state.rel_bit);
                    if ((i_state.outstanding_len == '0) && (i_item.pending_bytes != '0)) begin
                        n_st.outstanding_len = pend_sat;
                        n_st.rel_bit         = ~i_state.rel_bit;
                        send                 = 1'b1;
                        res.took_pending     = 1'b1;
                    end
                    res.hdr_seq_word = {send, i_state.out_seq};
                    res.hdr_ack_word = {i_state.in_rel_bit, i_state.in_seq};
                    n_st.out_seq     = i_state.out_seq + {{(rds_pkg::SEQ_W-1){1'b0}}, 1'b1};
                    if (send) begin
                        used_base               = rds_pkg::HDR_BYTES + n_st.outstanding_len;
                        res.reliable_sent_bytes = n_st.outstanding_len;
                        n_st.last_rel_seq       = n_st.out_seq;
                    end
                    used_total = {1'b0, used_base} + {1'b0, i_item.unreliable_bytes};
                    if (used_total <= {1'b0, i_max_packet_bytes}) begin
                        res.unreliable_included = 1'b1;
                        res.packet_bytes        = used_total[rds_pkg::LEN_W-1:0];
                    end else begin
                        res.packet_bytes        = used_base;
                    end
                    res.status = rds_pkg::ST_SENT;
                end
            end
            rds_pkg::ACT_RX: begin
                if (!i_item.from_remote) begin
                    res.status = rds_pkg::ST_WRONG_ADDR;
                end else if (rx_seq <= i_state.in_seq) begin
                    res.status = rds_pkg::ST_STALE;
                end else begin
                    if (gap != '0) begin
                        n_st.drop_cnt = i_state.drop_cnt + 32'd1;
                    end
                    if (i_item.rx_ack_word[31] == i_state.rel_bit) begin
                        n_st.outstanding_len = '0;
                    end
                    n_st.in_seq       = rx_seq;
                    n_st.peer_ack_seq = i_item.rx_ack_word[rds_pkg::SEQ_W-1:0];
                    n_st.peer_ack_bit = i_item.rx_ack_word[31];
                    if (i_item.rx_seq_word[31]) begin
                        n_st.in_rel_bit = ~i_state.in_rel_bit;
                    end
                    n_st.good_cnt    = i_state.good_cnt + 32'd1;
                    res.packets_lost = gap;
                    res.status       = rds_pkg::ST_ACCEPTED;
                end
            end
            default: begin
            end
        endcase
        res.reliable_idle = (n_st.outstanding_len == '0);
        res.drop_total    = n_st.drop_cnt;
        res.good_total    = n_st.good_cnt;
    end

    assign o_result     = res;
    assign o_next_state = n_st;

endmodule

[design/reliable_datagram_sequencer.sv]
// Datapath: an accepted item is registered in the input register, then its result in the
// result register. Throughput: one item per cycle while i_out_stall is low; the step logic
// between the two registers reads and updates the channel state in the same cycle.
// Reset (synchronous, active low): all sequence, ack and counter state cleared,
// both pipeline registers emptied, packet capacity set to 8200 bytes.
// Top level: reliable datagram sequencer channel with APB configuration.
module reliable_datagram_sequencer (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [rds_pkg::ADDR_W-1:0]    paddr,
    input  logic [rds_pkg::DATA_W-1:0]    pwdata,
    output logic [rds_pkg::DATA_W-1:0]    prdata,
    output logic                          pready,
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  logic                          i_action,
    input  logic [rds_pkg::LEN_W-1:0]     i_pending_bytes,
    input  logic                          i_pending_overflowed,
    input  logic [rds_pkg::LEN_W-1:0]     i_unreliable_bytes,
    input  logic                          i_from_remote,
    input  logic [31:0]                   i_rx_seq_word,
    input  logic [31:0]                   i_rx_ack_word,
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output logic [2:0]                    o_status,
    output logic [31:0]                   o_hdr_seq_word,
    output logic [31:0]                   o_hdr_ack_word,
    output logic [rds_pkg::LEN_W-1:0]     o_reliable_sent_bytes,
    output logic                          o_unreliable_included,
    output logic [rds_pkg::LEN_W-1:0]     o_packet_bytes,
    output logic                          o_took_pending,
    output logic [rds_pkg::SEQ_W-1:0]     o_packets_lost,
    output logic                          o_reliable_idle,
    output logic [rds_pkg::CNT_W-1:0]     o_drop_total,
    output logic [rds_pkg::CNT_W-1:0]     o_good_total
);

    logic [rds_pkg::LEN_W-1:0] max_packet_bytes;

    logic             r_in_valid;
    logic             n_in_valid;
    rds_pkg::t_item   r_in_item;
    rds_pkg::t_item   n_in_item;
    logic             r_out_valid;
    logic             n_out_valid;
    rds_pkg::t_result r_out_result;
    rds_pkg::t_result n_out_result;
    rds_pkg::t_state  r_state;
    rds_pkg::t_state  n_state;

    rds_pkg::t_item   in_item;
    rds_pkg::t_result step_result;
    rds_pkg::t_state  step_state;
    logic             in_take;
    logic             advance;
    logic             out_take;

    rds_cfg u_cfg (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .psel               (psel),
        .penable            (penable),
        .pwrite             (pwrite),
        .paddr              (paddr),
        .pwdata             (pwdata),
        .prdata             (prdata),
        .pready             (pready),
        .o_max_packet_bytes (max_packet_bytes)
    );

    rds_step u_step (
        .i_item             (r_in_item),
        .i_state            (r_state),
        .i_max_packet_bytes (max_packet_bytes),
        .o_result           (step_result),
        .o_next_state       (step_state)
    );

    assign in_item.action             = i_action;
    assign in_item.pending_bytes      = i_pending_bytes;
    assign in_item.pending_overflowed = i_pending_overflowed;
    assign in_item.unreliable_bytes   = i_unreliable_bytes;
    assign in_item.from_remote        = i_from_remote;
    assign in_item.rx_seq_word        = i_rx_seq_word;
    assign in_item.rx_ack_word        = i_rx_ack_word;

    // item moves into the result register when that register is empty or draining
    assign out_take   = r_out_valid && !i_out_stall;
    assign advance    = r_in_valid && (!r_out_valid || !i_out_stall);
    assign o_in_stall = r_in_valid && !advance;
    assign in_take    = i_in_valid && !o_in_stall;

    always_comb begin
        n_in_valid   = r_in_valid;
        n_in_item    = r_in_item;
        n_out_valid  = r_out_valid;
        n_out_result = r_out_result;
        n_state      = r_state;
        if (advance) begin
            n_in_valid = 1'b0;
        end
        if (in_take) begin
            n_in_valid = 1'b1;
            n_in_item  = in_item;
        end
        if (out_take) begin
            n_out_valid = 1'b0;
        end
        if (advance) begin
            n_out_valid  = 1'b1;
            n_out_result = step_result;
            n_state      = step_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_state     <= '0;
        end else begin
            r_in_valid  <= n_in_valid;
            r_out_valid <= n_out_valid;
            r_state     <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        r_in_item    <= n_in_item;
        r_out_result <= n_out_result;
    end

    assign o_out_valid           = r_out_valid;
    assign o_status              = r_out_result.status;
    assign o_hdr_seq_word        = r_out_result.hdr_seq_word;
    assign o_hdr_ack_word        = r_out_result.hdr_ack_word;
    assign o_reliable_sent_bytes = r_out_result.reliable_sent_bytes;
    assign o_unreliable_included = r_out_result.unreliable_included;
    assign o_packet_bytes        = r_out_result.packet_bytes;
    assign o_took_pending        = r_out_result.took_pending;
    assign o_packets_lost        = r_out_result.packets_lost;
    assign o_reliable_idle       = r_out_result.reliable_idle;
    assign o_drop_total          = r_out_result.drop_total;
    assign o_good_total          = r_out_result.good_total;

    a_outstanding_bounded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state.outstanding_len <= rds_pkg::MAX_MESSAGE)
        else $error("outstanding length above message limit");

    a_fatal_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state.fatal_flag |=> r_state.fatal_flag)
        else $error("fatal flag cleared without reset");

    a_good_only_on_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (advance && (step_result.status != rds_pkg::ST_ACCEPTED)) |=>
        $stable(r_state.good_cnt))
        else $error("good count moved on a non-accepted item");

    a_state_only_on_advance: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !advance |=> $stable(r_state))
        else $error("channel state changed with no item in step");

    a_result_matches_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        advance |=> (r_out_result.good_total == r_state.good_cnt) &&
                    (r_out_result.drop_total == r_state.drop_cnt))
        else $error("result counters differ from state");

endmodule

[sim/rds_checker.sv]
// Channel monitor for the reliable datagram sequencer: predicts each step and compares results.
module rds_checker
    import rds_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_psel,
    input  logic                  i_penable,
    input  logic                  i_pwrite,
    input  logic                  i_pready,
    input  logic [ADDR_W-1:0]     i_paddr,
    input  logic [DATA_W-1:0]     i_pwdata,
    input  logic                  i_in_valid,
    input  logic                  i_in_stall,
    input  logic                  i_action,
    input  logic [LEN_W-1:0]      i_pending_bytes,
    input  logic                  i_pending_overflowed,
    input  logic [LEN_W-1:0]      i_unreliable_bytes,
    input  logic                  i_from_remote,
    input  logic [31:0]           i_rx_seq_word,
    input  logic [31:0]           i_rx_ack_word,
    input  logic                  i_out_valid,
    input  logic                  i_out_stall,
    input  logic [2:0]            i_status,
    input  logic [31:0]           i_hdr_seq_word,
    input  logic [31:0]           i_hdr_ack_word,
    input  logic [LEN_W-1:0]      i_reliable_sent_bytes,
    input  logic                  i_unreliable_included,
    input  logic [LEN_W-1:0]      i_packet_bytes,
    input  logic                  i_took_pending,
    input  logic [SEQ_W-1:0]      i_packets_lost,
    input  logic                  i_reliable_idle,
    input  logic [CNT_W-1:0]      i_drop_total,
    input  logic [CNT_W-1:0]      i_good_total,
    output int                    o_fail_count,
    output int                    o_awaited
);
    timeunit 1ns;
    timeprecision 1ps;

    t_state           chan;
    logic [LEN_W-1:0] capacity;
    t_result          step_outcomes_q[$];
    int               mismatches = 0;
    t_item            seen_item;
    t_result          got_result;
    t_result          want_result;

    // One channel step: header build on transmit, sequence/ack bookkeeping on receive.
    function automatic t_result advance_channel(input t_item it);
        t_result          r;
        logic             flagged;
        logic [SEQ_W-1:0] rx_seq;
        logic [SEQ_W-1:0] gap;
        int unsigned      used;
        r = '0;
        if (it.action == ACT_TX) begin
            if (it.pending_overflowed) begin
                chan.fatal_flag = 1'b1;
                r.status = ST_FATAL;
            end else begin
                // peer acked a later packet without our bit: resend
                flagged = (chan.peer_ack_seq > chan.last_rel_seq)
                          && (chan.peer_ack_bit != chan.rel_bit);
                if (chan.outstanding_len == '0 && it.pending_bytes != '0) begin
                    chan.outstanding_len = (it.pending_bytes > MAX_MESSAGE) ? MAX_MESSAGE
                                                                           : it.pending_bytes;
                    chan.rel_bit = ~chan.rel_bit;
                    flagged = 1'b1;
                    r.took_pending = 1'b1;
                end
                r.hdr_seq_word = {flagged, chan.out_seq};
                r.hdr_ack_word = {chan.in_rel_bit, chan.in_seq};
                chan.out_seq = chan.out_seq + 1'b1;
                used = HDR_BYTES;
                if (flagged) begin
                    used = used + chan.outstanding_len;
                    r.reliable_sent_bytes = chan.outstanding_len;
                    chan.last_rel_seq = chan.out_seq;
                end
                if (used + it.unreliable_bytes <= capacity) begin
                    used = used + it.unreliable_bytes;
                    r.unreliable_included = 1'b1;
                end
                r.packet_bytes = used[LEN_W-1:0];
                r.status = ST_SENT;
            end
        end else if (!it.from_remote) begin
            r.status = ST_WRONG_ADDR;
        end else begin
            rx_seq = it.rx_seq_word[SEQ_W-1:0];
            if (rx_seq <= chan.in_seq) begin
                r.status = ST_STALE;
            end else begin
                gap = rx_seq - chan.in_seq - 1'b1;
                if (gap != '0) chan.drop_cnt = chan.drop_cnt + 1'b1;
                if (it.rx_ack_word[31] == chan.rel_bit) chan.outstanding_len = '0;
                chan.in_seq       = rx_seq;
                chan.peer_ack_seq = it.rx_ack_word[SEQ_W-1:0];
                chan.peer_ack_bit = it.rx_ack_word[31];
                if (it.rx_seq_word[31]) chan.in_rel_bit = ~chan.in_rel_bit;
                chan.good_cnt   = chan.good_cnt + 1'b1;
                r.packets_lost  = gap;
                r.status        = ST_ACCEPTED;
            end
        end
        r.reliable_idle = (chan.outstanding_len == '0);
        r.drop_total    = chan.drop_cnt;
        r.good_total    = chan.good_cnt;
        return r;
    endfunction

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (want !== got) begin
            mismatches++;
            if (mismatches <= 10)
                $display("mismatch on %s: expected %h, got %h", name, want, got);
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            chan     = '0;
            capacity = MAX_PKT_RESET;
            step_outcomes_q.delete();
        end else begin
            if (i_psel && i_penable && i_pwrite && i_pready && i_paddr == ADDR_MAX_PACKET)
                capacity = i_pwdata[LEN_W-1:0];

            if (i_out_valid && !i_out_stall) begin
                got_result.status              = t_status'(i_status);
                got_result.hdr_seq_word        = i_hdr_seq_word;
                got_result.hdr_ack_word        = i_hdr_ack_word;
                got_result.reliable_sent_bytes = i_reliable_sent_bytes;
                got_result.unreliable_included = i_unreliable_included;
                got_result.packet_bytes        = i_packet_bytes;
                got_result.took_pending        = i_took_pending;
                got_result.packets_lost        = i_packets_lost;
                got_result.reliable_idle       = i_reliable_idle;
                got_result.drop_total          = i_drop_total;
                got_result.good_total          = i_good_total;
                if (step_outcomes_q.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected result: status %0d seq %h",
                                 i_status, i_hdr_seq_word);
                end else begin
                    want_result = step_outcomes_q.pop_front();
                    check_field("status", want_result.status, got_result.status);
                    check_field("hdr_seq_word", want_result.hdr_seq_word,
                                got_result.hdr_seq_word);
                    check_field("hdr_ack_word", want_result.hdr_ack_word,
                                got_result.hdr_ack_word);
                    check_field("reliable_sent_bytes", want_result.reliable_sent_bytes,
                                got_result.reliable_sent_bytes);
                    check_field("unreliable_included", want_result.unreliable_included,
                                got_result.unreliable_included);
                    check_field("packet_bytes", want_result.packet_bytes,
                                got_result.packet_bytes);
                    check_field("took_pending", want_result.took_pending,
                                got_result.took_pending);
                    check_field("packets_lost", want_result.packets_lost,
                                got_result.packets_lost);
                    check_field("reliable_idle", want_result.reliable_idle,
                                got_result.reliable_idle);
                    check_field("drop_total", want_result.drop_total, got_result.drop_total);
                    check_field("good_total", want_result.good_total, got_result.good_total);
                end
            end

            if (i_in_valid && !i_in_stall) begin
                seen_item.action             = i_action;
                seen_item.pending_bytes      = i_pending_bytes;
                seen_item.pending_overflowed = i_pending_overflowed;
                seen_item.unreliable_bytes   = i_unreliable_bytes;
                seen_item.from_remote        = i_from_remote;
                seen_item.rx_seq_word        = i_rx_seq_word;
                seen_item.rx_ack_word        = i_rx_ack_word;
                step_outcomes_q.push_back(advance_channel(seen_item));
            end
        end
        o_fail_count <= mismatches;
        o_awaited    <= step_outcomes_q.size();
    end

endmodule

[sim/testbench.sv]
// Top of the sequencer regression: clock, reset, traffic, configuration and verdict.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;
    import rds_pkg::*;

    localparam int CYCLE_LIMIT = 400000;
    localparam int LONG_HOLD   = 300;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               psel = 1'b0;
    logic               penable = 1'b0;
    logic               pwrite = 1'b0;
    logic [ADDR_W-1:0]  paddr = '0;
    logic [DATA_W-1:0]  pwdata = '0;
    logic [DATA_W-1:0]  prdata;
    logic               pready;
    logic               i_in_valid = 1'b0;
    logic               o_in_stall;
    logic               i_action = 1'b0;
    logic [LEN_W-1:0]   i_pending_bytes = '0;
    logic               i_pending_overflowed = 1'b0;
    logic [LEN_W-1:0]   i_unreliable_bytes = '0;
    logic               i_from_remote = 1'b0;
    logic [31:0]        i_rx_seq_word = '0;
    logic [31:0]        i_rx_ack_word = '0;
    logic               o_out_valid;
    logic               i_out_stall = 1'b0;
    logic [2:0]         o_status;
    logic [31:0]        o_hdr_seq_word;
    logic [31:0]        o_hdr_ack_word;
    logic [LEN_W-1:0]   o_reliable_sent_bytes;
    logic               o_unreliable_included;
    logic [LEN_W-1:0]   o_packet_bytes;
    logic               o_took_pending;
    logic [SEQ_W-1:0]   o_packets_lost;
    logic               o_reliable_idle;
    logic [CNT_W-1:0]   o_drop_total;
    logic [CNT_W-1:0]   o_good_total;

    int                 fail_count;
    int                 awaited;
    int                 cycles = 0;
    bit                 hold_armed = 1'b0;

    t_item              traffic_q[$];
    logic [SEQ_W-1:0]   peer_seq = '0;  // highest sequence the block has accepted
    logic [SEQ_W-1:0]   tx_count = '0;  // packets the block has built

    reliable_datagram_sequencer u_top (
        .i_clk                 (i_clk),
        .i_rst_n               (i_rst_n),
        .psel                  (psel),
        .penable               (penable),
        .pwrite                (pwrite),
        .paddr                 (paddr),
        .pwdata                (pwdata),
        .prdata                (prdata),
        .pready                (pready),
        .i_in_valid            (i_in_valid),
        .o_in_stall            (o_in_stall),
        .i_action              (i_action),
        .i_pending_bytes       (i_pending_bytes),
        .i_pending_overflowed  (i_pending_overflowed),
        .i_unreliable_bytes    (i_unreliable_bytes),
        .i_from_remote         (i_from_remote),
        .i_rx_seq_word         (i_rx_seq_word),
        .i_rx_ack_word         (i_rx_ack_word),
        .o_out_valid           (o_out_valid),
        .i_out_stall           (i_out_stall),
        .o_status              (o_status),
        .o_hdr_seq_word        (o_hdr_seq_word),
        .o_hdr_ack_word        (o_hdr_ack_word),
        .o_reliable_sent_bytes (o_reliable_sent_bytes),
        .o_unreliable_included (o_unreliable_included),
        .o_packet_bytes        (o_packet_bytes),
        .o_took_pending        (o_took_pending),
        .o_packets_lost        (o_packets_lost),
        .o_reliable_idle       (o_reliable_idle),
        .o_drop_total          (o_drop_total),
        .o_good_total          (o_good_total)
    );

    rds_checker u_checker (
        .i_clk                 (i_clk),
        .i_rst_n               (i_rst_n),
        .i_psel                (psel),
        .i_penable             (penable),
        .i_pwrite              (pwrite),
        .i_pready              (pready),
        .i_paddr               (paddr),
        .i_pwdata              (pwdata),
        .i_in_valid            (i_in_valid),
        .i_in_stall            (o_in_stall),
        .i_action              (i_action),
        .i_pending_bytes       (i_pending_bytes),
        .i_pending_overflowed  (i_pending_overflowed),
        .i_unreliable_bytes    (i_unreliable_bytes),
        .i_from_remote         (i_from_remote),
        .i_rx_seq_word         (i_rx_seq_word),
        .i_rx_ack_word         (i_rx_ack_word),
        .i_out_valid           (o_out_valid),
        .i_out_stall           (i_out_stall),
        .i_status              (o_status),
        .i_hdr_seq_word        (o_hdr_seq_word),
        .i_hdr_ack_word        (o_hdr_ack_word),
        .i_reliable_sent_bytes (o_reliable_sent_bytes),
        .i_unreliable_included (o_unreliable_included),
        .i_packet_bytes        (o_packet_bytes),
        .i_took_pending        (o_took_pending),
        .i_packets_lost        (o_packets_lost),
        .i_reliable_idle       (o_reliable_idle),
        .i_drop_total          (o_drop_total),
        .i_good_total          (o_good_total),
        .o_fail_count          (fail_count),
        .o_awaited             (awaited)
    );

    always #10 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    // Receiver: windows of random stall density, one long hold-off once armed.
    initial begin
        int  window;
        int  density;
        bit  hold_done;
        hold_done = 1'b0;
        @(posedge i_clk);
        forever begin
            if (hold_armed && !hold_done) begin
                i_out_stall <= 1'b1;
                repeat (LONG_HOLD) @(posedge i_clk);
                hold_done = 1'b1;
            end
            window = $urandom_range(8, 64);
            case ($urandom_range(0, 3))
                0: density = 0;
                1: density = 30;
                2: density = 60;
                default: density = 90;
            endcase
            repeat (window) begin
                i_out_stall <= ($urandom_range(1, 100) <= density);
                @(posedge i_clk);
            end
        end
    end

    function automatic logic [LEN_W-1:0] random_length();
        case ($urandom_range(0, 9))
            0, 1, 2: return '0;
            3, 4, 5, 6: return LEN_W'($urandom_range(1, 300));
            7, 8: return LEN_W'($urandom_range(301, 8192));
            default: return LEN_W'($urandom_range(8193, 16383));
        endcase
    endfunction

    task automatic queue_tx(input logic [LEN_W-1:0] pend, input logic [LEN_W-1:0] unrel,
                            input logic overflowed);
        t_item it;
        it.action             = ACT_TX;
        it.pending_bytes      = pend;
        it.pending_overflowed = overflowed;
        it.unreliable_bytes   = unrel;
        it.from_remote        = 1'($urandom_range(0, 1));
        it.rx_seq_word        = $urandom;
        it.rx_ack_word        = $urandom;
        if (!overflowed) tx_count = tx_count + 1'b1;
        traffic_q.push_back(it);
    endtask

    task automatic queue_rx(input logic remote, input logic [31:0] seq_word,
                            input logic [31:0] ack_word);
        t_item it;
        it.action             = ACT_RX;
        it.pending_bytes      = random_length();
        it.pending_overflowed = 1'($urandom_range(0, 1));
        it.unreliable_bytes   = random_length();
        it.from_remote        = remote;
        it.rx_seq_word        = seq_word;
        it.rx_ack_word        = ack_word;
        if (remote && seq_word[SEQ_W-1:0] > peer_seq) peer_seq = seq_word[SEQ_W-1:0];
        traffic_q.push_back(it);
    endtask

    // Mostly an in-order peer acking recent packets; some gaps, replays and foreign noise.
    task automatic queue_traffic(input int count);
        int               roll;
        logic             flag;
        logic             ack_bit;
        logic [SEQ_W-1:0] seq;
        logic [SEQ_W-1:0] ack;
        repeat (count) begin
            roll    = $urandom_range(0, 99);
            flag    = 1'($urandom_range(0, 1));
            ack_bit = 1'($urandom_range(0, 1));
            if (roll < 45) begin
                queue_tx(random_length(), random_length(), $urandom_range(0, 99) < 3);
            end else if (roll < 90) begin
                roll = $urandom_range(0, 99);
                if (roll < 75)
                    seq = peer_seq + 1'b1;
                else if (roll < 87)
                    seq = peer_seq + SEQ_W'($urandom_range(2, 6));
                else if (roll < 90)
                    seq = peer_seq + SEQ_W'($urandom_range(7, 65536));
                else
                    seq = peer_seq - SEQ_W'($urandom_range(0, (peer_seq < 3) ? peer_seq : 3));
                if ($urandom_range(0, 99) < 85)
                    ack = tx_count - SEQ_W'($urandom_range(0, (tx_count < 2) ? tx_count : 2));
                else
                    ack = SEQ_W'($urandom);
                queue_rx(1'b1, {flag, seq}, {ack_bit, ack});
            end else if (roll < 97) begin
                queue_rx(1'b0, $urandom, $urandom);
            end else begin
                seq = SEQ_W'($urandom_range(0, peer_seq));
                queue_rx(1'b1, {flag, seq}, $urandom);
            end
        end
    endtask

    task automatic drive_traffic();
        t_item it;
        int    burst_left;
        int    gap;
        burst_left = $urandom_range(1, 24);
        while (traffic_q.size() != 0) begin
            it = traffic_q.pop_front();
            i_in_valid           <= 1'b1;
            i_action             <= it.action;
            i_pending_bytes      <= it.pending_bytes;
            i_pending_overflowed <= it.pending_overflowed;
            i_unreliable_bytes   <= it.unreliable_bytes;
            i_from_remote        <= it.from_remote;
            i_rx_seq_word        <= it.rx_seq_word;
            i_rx_ack_word        <= it.rx_ack_word;
            do @(posedge i_clk); while (o_in_stall);
            burst_left--;
            if (burst_left == 0 && traffic_q.size() != 0) begin
                burst_left = $urandom_range(1, 24);
                gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
                if (gap != 0) begin
                    i_in_valid <= 1'b0;
                    repeat (gap) @(posedge i_clk);
                end
            end
        end
        i_in_valid <= 1'b0;
    endtask

    task automatic settle();
        @(posedge i_clk);
        while (awaited != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_capacity(input logic [LEN_W-1:0] bytes);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= ADDR_MAX_PACKET;
        pwdata  <= DATA_W'(bytes);
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    initial begin
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        write_capacity(14'd1000);
        queue_tx(14'd0, 14'd0, 1'b0);
        queue_tx(14'd100, 14'd50, 1'b0);
        queue_tx(14'd200, 14'd0, 1'b0);          // message already outstanding
        queue_rx(1'b0, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        queue_rx(1'b1, 32'd1, {1'b0, 31'd5});    // later ack, wrong bit
        queue_tx(14'd0, 14'd892, 1'b0);          // resend, exactly fills capacity
        queue_tx(14'd0, 14'd893, 1'b0);          // one byte over
        queue_rx(1'b1, 32'd1, 32'd0);            // duplicate
        queue_rx(1'b1, 32'd0, 32'd0);            // older
        queue_rx(1'b1, {1'b1, 31'd4}, {1'b1, 31'd6});
        queue_tx(14'h3FFF, 14'h3FFF, 1'b0);      // oversized pending message
        queue_tx(14'd0, 14'd0, 1'b1);
        queue_tx(14'd0, 14'd992, 1'b0);
        queue_tx(14'd0, 14'd993, 1'b0);
        queue_rx(1'b1, 32'd5, {1'b0, 31'd9});
        queue_tx(14'd8192, 14'd0, 1'b0);
        queue_rx(1'b1, 32'd6, 32'd0);
        queue_tx(14'd0, 14'd0, 1'b1);
        queue_tx(14'd1, 14'd0, 1'b0);
        drive_traffic();
        settle();

        write_capacity(HDR_BYTES);
        queue_traffic(300);
        drive_traffic();
        settle();

        write_capacity(MAX_PKT_RESET);
        hold_armed = 1'b1;
        queue_traffic(420);
        drive_traffic();
        settle();

        write_capacity(LEN_W'($urandom_range(9, 8199)));
        queue_traffic(330);
        drive_traffic();
        settle();

        write_capacity(14'h3FFF);
        queue_traffic(300);
        // top of the sequence space
        queue_rx(1'b1, {1'b1, 31'h7FFF_FFFE}, $urandom);
        queue_rx(1'b1, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        queue_rx(1'b1, 32'h7FFF_FFFF, 32'd0);
        queue_tx(14'd0, 14'h3FFF, 1'b0);
        drive_traffic();
        settle();

        if (fail_count == 0 && awaited == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule
